FILE: hdl/voa_pkg.sv
// Shared types, codes and constants of the velocity-obstacle avoider.
package voa_pkg;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_TEST,
      ST_SQRT,
      ST_SDONE,
      ST_CORD,
      ST_CDONE,
      ST_CONE,
      ST_EDGE_X,
      ST_EDGE_Y,
      ST_EDGE_WR,
      ST_EMIT
   } state_type;

   // What the angle unit is computing at the moment.
   typedef enum logic [1:0] {
      JOB_APEX,
      JOB_CENTER,
      JOB_VANG,
      JOB_SINCOS
   } job_type;

   // What the square root unit is computing at the moment.
   typedef enum logic {
      SQ_APEX,
      SQ_MAG
   } sq_job_type;

   // Starting point of one angle unit run.
   typedef struct packed {
      logic signed [51:0] x;
      logic signed [51:0] y;
      logic signed [32:0] z;
      logic               zero;
   } cord_load_type;

   // Command codes carried in tuser.
   localparam logic [1:0] CMD_OWN      = 2'd0;
   localparam logic [1:0] CMD_NEIGHBOR = 2'd1;
   localparam logic [1:0] CMD_EMIT     = 2'd2;

   // Register indexes of the write port.
   localparam logic [1:0] REG_SAFETY_RADIUS      = 2'd0;
   localparam logic [1:0] REG_TIME_HORIZON       = 2'd1;
   localparam logic [1:0] REG_OVERRIDE_THRESHOLD = 2'd2;

   localparam logic [15:0] RESET_SAFETY_RADIUS      = 16'd2560;
   localparam logic [15:0] RESET_TIME_HORIZON       = 16'd1280;
   localparam logic [15:0] RESET_OVERRIDE_THRESHOLD = 16'd655;

   // Multiplier step codes.
   localparam logic [3:0] STEP_RP0 = 4'd0;
   localparam logic [3:0] STEP_RP1 = 4'd1;
   localparam logic [3:0] STEP_RP2 = 4'd2;
   localparam logic [3:0] STEP_RV0 = 4'd3;
   localparam logic [3:0] STEP_RV1 = 4'd4;
   localparam logic [3:0] STEP_RV2 = 4'd5;
   localparam logic [3:0] STEP_RT  = 4'd6;
   localparam logic [3:0] STEP_RT2 = 4'd7;
   localparam logic [3:0] STEP_R2  = 4'd8;
   localparam logic [3:0] STEP_D0  = 4'd9;
   localparam logic [3:0] STEP_D1  = 4'd10;
   localparam logic [3:0] STEP_D2  = 4'd11;

   // Binary angles: a full turn is 2^32.
   localparam logic signed [32:0] ANG_HALF_PI = 33'sh040000000;
   localparam logic signed [32:0] ANG_PI      = 33'sh080000000;

   // Inverse CORDIC gain in Q2.30.
   localparam logic signed [51:0] CORDIC_K = 52'sd652032874;

   // atan(2^-i) as binary angles.
   localparam logic [29:0] ATAN_TAB [24] = '{
      30'h20000000, 30'h12E4051E, 30'h09FB385B, 30'h051111D4,
      30'h028B0D43, 30'h0145D7E1, 30'h00A2F61E, 30'h00517C55,
      30'h0028BE53, 30'h00145F2F, 30'h000A2F98, 30'h000517CC,
      30'h00028BE6, 30'h000145F3, 30'h0000A2F9, 30'h0000517C,
      30'h000028BE, 30'h0000145F, 30'h00000A2F, 30'h00000517,
      30'h0000028B, 30'h00000145, 30'h000000A2, 30'h00000051
   };

endpackage

FILE: hdl/velocity_obstacle_avoider_unit.sv
// Velocity-obstacle avoider: sequencer with a shared multiplier, root and CORDIC unit.
// An own-odometry word (cmd 0) or an unknown command leaves the sequencer idle.
// An emit word (cmd 2) runs the multiplier steps D0 to D2 before the result word is shown.
// A neighbor word returns to idle after the range test when out of range; otherwise it
// runs through the square root and the CORDIC angle runs, at a pace
// set by the two-bit-per-cycle square root and the one-step-per-cycle CORDIC.
// Synchronous reset restores the register defaults and clears all odometry state.
module velocity_obstacle_avoider_unit #(
   parameter int ANGLE_ITERATIONS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[23:0], pos_y[47:24], pos_z[71:48], vel_x[87:72], vel_y[103:88], vel_z[119:104]
   input  logic [119:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // cmd_vel_x[15:0], cmd_vel_y[31:16], cmd_vel_z[47:32]
   output logic [47:0]  rsp_tdata,
   // override[0]
   output logic         rsp_tuser,
   input  logic         csr_we,
   input  logic [1:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);
   import voa_pkg::*;

   localparam logic [4:0] LAST_ITER = 5'(ANGLE_ITERATIONS - 1);

   // Saturate a wide signed sum to a 16-bit velocity.
   function automatic logic signed [15:0] sat16(input logic signed [28:0] v);
      logic signed [15:0] r;
      if (v > 29'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -29'sd32768) begin
         r = -16'sh8000;
      end else begin
         r = 16'(v);
      end
      return r;
   endfunction

   // Fold the vector into the right half plane before CORDIC vectoring.
   function automatic cord_load_type vec_load(input logic signed [51:0] y,
                                              input logic signed [51:0] x);
      cord_load_type r;
      r.x    = x;
      r.y    = y;
      r.z    = '0;
      r.zero = (x == 52'sd0) && (y == 52'sd0);
      if (x < 52'sd0) begin
         if (y >= 52'sd0) begin
            r.x = y;
            r.y = -x;
            r.z = ANG_HALF_PI;
         end else begin
            r.x = -y;
            r.y = x;
            r.z = -ANG_HALF_PI;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type  state_ff, state_in;
   job_type    job_ff, job_in;
   sq_job_type sq_job_ff, sq_job_in;

   logic [15:0] radius_ff, radius_in;
   logic [15:0] horizon_ff, horizon_in;
   logic [15:0] thresh_ff, thresh_in;

   logic signed [23:0] own_pos_ff [3];
   logic signed [23:0] own_pos_in [3];
   logic signed [15:0] own_vel_ff [3];
   logic signed [15:0] own_vel_in [3];
   logic signed [15:0] avoid_ff [3];
   logic signed [15:0] avoid_in [3];
   logic signed [15:0] nb_vel_ff [2];
   logic signed [15:0] nb_vel_in [2];
   logic signed [24:0] rp_ff [3];
   logic signed [24:0] rp_in [3];
   logic signed [16:0] rv_ff [3];
   logic signed [16:0] rv_in [3];

   logic [3:0]         step_ff, step_in;
   logic signed [65:0] prod_ff, prod_in;
   logic [49:0]        dsq_ff, dsq_in;
   logic [33:0]        vsq_ff, vsq_in;
   logic [31:0]        rt_ff, rt_in;
   logic [47:0]        lim_ff, lim_in;
   logic [31:0]        r2_ff, r2_in;

   logic [49:0] sq_rem_ff, sq_rem_in;
   logic [49:0] sq_res_ff, sq_res_in;
   logic [49:0] sq_bit_ff, sq_bit_in;

   logic signed [51:0] cx_ff, cx_in;
   logic signed [51:0] cy_ff, cy_in;
   logic signed [32:0] cz_ff, cz_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic               vect_ff, vect_in;
   logic               zero_ff, zero_in;
   logic               neg_ff, neg_in;

   logic signed [31:0] apex_ff, apex_in;
   logic signed [31:0] center_ff, center_in;
   logic signed [31:0] vang_ff, vang_in;
   logic               left_ff, left_in;
   logic [25:0]        mag_ff, mag_in;
   logic signed [31:0] cos_ff, cos_in;
   logic signed [31:0] sin_ff, sin_in;
   logic signed [27:0] ex_ff, ex_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;
   logic        rsp_user_ff, rsp_user_in;

   // ---------------------------------------------------------------------
   // Input fields and shared conditions
   // ---------------------------------------------------------------------
   logic               accept;
   logic [1:0]         in_cmd;
   logic signed [23:0] in_pos [3];
   logic signed [15:0] in_vel [3];

   assign accept    = req_tvalid & req_tready;
   assign in_cmd    = req_tuser;
   assign in_pos[0] = signed'(req_tdata[23:0]);
   assign in_pos[1] = signed'(req_tdata[47:24]);
   assign in_pos[2] = signed'(req_tdata[71:48]);
   assign in_vel[0] = signed'(req_tdata[87:72]);
   assign in_vel[1] = signed'(req_tdata[103:88]);
   assign in_vel[2] = signed'(req_tdata[119:104]);

   // The block takes a word only when idle and the result register is free.
   assign req_tready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   logic               test_far, test_inside, cone_miss, cord_last, sq_last;
   logic signed [31:0] diff;
   logic signed [33:0] absd;

   assign test_far    = dsq_ff > 50'(lim_ff);
   assign test_inside = dsq_ff <= 50'(r2_ff);
   assign diff        = vang_ff - center_ff;
   assign absd        = (diff < 32'sd0) ? -34'(diff) : 34'(diff);
   assign cone_miss   = absd >= 34'(apex_ff);
   assign cord_last   = cnt_ff == LAST_ITER;
   assign sq_last     = sq_bit_ff[0];

   // ---------------------------------------------------------------------
   // Shared multiplier, one product per cycle, registered.
   // ---------------------------------------------------------------------
   logic signed [32:0] mul_a, mul_b;
   logic signed [16:0] dv [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dv[k] = 17'(avoid_ff[k]) - 17'(own_vel_ff[k]);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL: begin
            case (step_ff)
               STEP_RP0: begin mul_a = 33'(rp_ff[0]); mul_b = 33'(rp_ff[0]); end
               STEP_RP1: begin mul_a = 33'(rp_ff[1]); mul_b = 33'(rp_ff[1]); end
               STEP_RP2: begin mul_a = 33'(rp_ff[2]); mul_b = 33'(rp_ff[2]); end
               STEP_RV0: begin mul_a = 33'(rv_ff[0]); mul_b = 33'(rv_ff[0]); end
               STEP_RV1: begin mul_a = 33'(rv_ff[1]); mul_b = 33'(rv_ff[1]); end
               STEP_RV2: begin mul_a = 33'(rv_ff[2]); mul_b = 33'(rv_ff[2]); end
               STEP_RT:  begin mul_a = 33'(radius_ff); mul_b = 33'(horizon_ff); end
               STEP_RT2: begin mul_a = 33'(rt_ff); mul_b = 33'(rt_ff); end
               STEP_R2:  begin mul_a = 33'(radius_ff); mul_b = 33'(radius_ff); end
               STEP_D0:  begin mul_a = 33'(dv[0]); mul_b = 33'(dv[0]); end
               STEP_D1:  begin mul_a = 33'(dv[1]); mul_b = 33'(dv[1]); end
               STEP_D2:  begin mul_a = 33'(dv[2]); mul_b = 33'(dv[2]); end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_EDGE_X: begin mul_a = 33'(mag_ff); mul_b = 33'(cos_ff); end
         ST_EDGE_Y: begin mul_a = 33'(mag_ff); mul_b = 33'(sin_ff); end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 66'(mul_a) * 66'(mul_b);

   // Edge component: product of speed and cos or sin, Q.38 down to Q.0, half up.
   logic signed [65:0] prod_rnd;
   logic signed [27:0] edge_val;
   assign prod_rnd = prod_ff + (66'sd1 <<< 37);
   assign edge_val = 28'(prod_rnd >>> 38);

   // ---------------------------------------------------------------------
   // Square root step: two bits of the radicand per cycle.
   // ---------------------------------------------------------------------
   logic [49:0] sq_trial;
   assign sq_trial = sq_res_ff + sq_bit_ff;

   // ---------------------------------------------------------------------
   // CORDIC step, vectoring or rotation.
   // ---------------------------------------------------------------------
   logic signed [51:0] cdx, cdy;
   logic signed [32:0] ctab;
   logic               cup;
   logic signed [31:0] zres;

   assign cdx  = cx_ff >>> cnt_ff;
   assign cdy  = cy_ff >>> cnt_ff;
   assign ctab = 33'(ATAN_TAB[cnt_ff]);
   assign cup  = vect_ff ? !(cy_ff > 52'sd0) : (cz_ff >= 33'sd0);
   assign zres = zero_ff ? 32'sd0 : signed'(cz_ff[31:0]);

   // Start points of the angle unit runs.
   cord_load_type ld_apex, ld_center, ld_vang;
   logic signed [31:0] esc;
   logic signed [32:0] esc_wide;

   assign ld_apex   = vec_load(52'(radius_ff) <<< 24, 52'(sq_res_ff[25:0]) <<< 24);
   assign ld_center = vec_load(52'(rp_ff[1]) <<< 24, 52'(rp_ff[0]) <<< 24);
   assign ld_vang   = vec_load(52'(rv_ff[1]) <<< 24, 52'(rv_ff[0]) <<< 24);
   assign esc       = left_ff ? (center_ff + apex_ff) : (center_ff - apex_ff);
   assign esc_wide  = 33'(esc);

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (in_cmd == CMD_NEIGHBOR || in_cmd == CMD_EMIT)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_ACC;
         ST_ACC: begin
            if (step_ff == STEP_R2) begin
               state_in = ST_TEST;
            end else if (step_ff == STEP_D2) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_TEST: begin
            if (test_far) begin
               state_in = ST_IDLE;
            end else if (test_inside) begin
               state_in = ST_CORD;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_last) begin
               state_in = ST_SDONE;
            end
         end
         ST_SDONE: state_in = ST_CORD;
         ST_CORD: begin
            if (cord_last) begin
               state_in = ST_CDONE;
            end
         end
         ST_CDONE: begin
            case (job_ff)
               JOB_VANG:   state_in = ST_CONE;
               JOB_SINCOS: state_in = ST_EDGE_X;
               default:    state_in = ST_CORD;
            endcase
         end
         ST_CONE:    state_in = cone_miss ? ST_IDLE : ST_SQRT;
         ST_EDGE_X:  state_in = ST_EDGE_Y;
         ST_EDGE_Y:  state_in = ST_EDGE_WR;
         ST_EDGE_WR: state_in = ST_IDLE;
         ST_EMIT:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath and outputs
   // ---------------------------------------------------------------------
   always_comb begin
      job_in     = job_ff;
      sq_job_in  = sq_job_ff;
      radius_in  = radius_ff;
      horizon_in = horizon_ff;
      thresh_in  = thresh_ff;
      own_pos_in = own_pos_ff;
      own_vel_in = own_vel_ff;
      avoid_in   = avoid_ff;
      nb_vel_in  = nb_vel_ff;
      rp_in      = rp_ff;
      rv_in      = rv_ff;
      step_in    = step_ff;
      dsq_in     = dsq_ff;
      vsq_in     = vsq_ff;
      rt_in      = rt_ff;
      lim_in     = lim_ff;
      r2_in      = r2_ff;
      sq_rem_in  = sq_rem_ff;
      sq_res_in  = sq_res_ff;
      sq_bit_in  = sq_bit_ff;
      cx_in      = cx_ff;
      cy_in      = cy_ff;
      cz_in      = cz_ff;
      cnt_in     = cnt_ff;
      vect_in    = vect_ff;
      zero_in    = zero_ff;
      neg_in     = neg_ff;
      apex_in    = apex_ff;
      center_in  = center_ff;
      vang_in    = vang_ff;
      left_in    = left_ff;
      mag_in     = mag_ff;
      cos_in     = cos_ff;
      sin_in     = sin_ff;
      ex_in      = ex_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_addr)
            REG_SAFETY_RADIUS:      radius_in  = csr_wdata;
            REG_TIME_HORIZON:       horizon_in = csr_wdata;
            REG_OVERRIDE_THRESHOLD: thresh_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (in_cmd)
                  CMD_OWN: begin
                     own_pos_in = in_pos;
                     own_vel_in = in_vel;
                     avoid_in   = in_vel;
                  end
                  CMD_NEIGHBOR: begin
                     for (int k = 0; k < 3; k++) begin
                        rp_in[k] = 25'(in_pos[k]) - 25'(own_pos_ff[k]);
                        rv_in[k] = 17'(own_vel_ff[k]) - 17'(in_vel[k]);
                     end
                     nb_vel_in[0] = in_vel[0];
                     nb_vel_in[1] = in_vel[1];
                     dsq_in  = '0;
                     vsq_in  = '0;
                     step_in = STEP_RP0;
                  end
                  CMD_EMIT: begin
                     vsq_in  = '0;
                     step_in = STEP_D0;
                  end
                  default: ;
               endcase
            end
         end
         ST_ACC: begin
            case (step_ff)
               STEP_RP0, STEP_RP1, STEP_RP2: dsq_in = dsq_ff + prod_ff[49:0];
               STEP_RT:  rt_in  = prod_ff[31:0];
               STEP_RT2: lim_in = prod_ff[63:16];
               STEP_R2:  r2_in  = prod_ff[31:0];
               default:  vsq_in = vsq_ff + prod_ff[33:0];
            endcase
            step_in = step_ff + 4'd1;
         end
         ST_TEST: begin
            // Inside the radius the cone opens to a right angle.
            apex_in   = 32'(ANG_HALF_PI);
            cx_in     = ld_center.x;
            cy_in     = ld_center.y;
            cz_in     = ld_center.z;
            zero_in   = ld_center.zero;
            vect_in   = 1'b1;
            cnt_in    = '0;
            job_in    = JOB_CENTER;
            sq_rem_in = dsq_ff - 50'(r2_ff);
            sq_res_in = '0;
            sq_bit_in = 50'(1) << 48;
            sq_job_in = SQ_APEX;
         end
         ST_SQRT: begin
            if (sq_rem_ff >= sq_trial) begin
               sq_rem_in = sq_rem_ff - sq_trial;
               sq_res_in = (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_bit_in = sq_bit_ff >> 2;
         end
         ST_SDONE: begin
            cnt_in = '0;
            if (sq_job_ff == SQ_APEX) begin
               cx_in   = ld_apex.x;
               cy_in   = ld_apex.y;
               cz_in   = ld_apex.z;
               zero_in = ld_apex.zero;
               vect_in = 1'b1;
               job_in  = JOB_APEX;
            end else begin
               mag_in  = sq_res_ff[25:0];
               cx_in   = CORDIC_K;
               cy_in   = '0;
               zero_in = 1'b0;
               vect_in = 1'b0;
               job_in  = JOB_SINCOS;
               // Fold the edge heading into the right half plane.
               if (esc_wide > ANG_HALF_PI) begin
                  cz_in  = esc_wide - ANG_PI;
                  neg_in = 1'b1;
               end else if (esc_wide < -ANG_HALF_PI) begin
                  cz_in  = esc_wide + ANG_PI;
                  neg_in = 1'b1;
               end else begin
                  cz_in  = esc_wide;
                  neg_in = 1'b0;
               end
            end
         end
         ST_CORD: begin
            if (cup) begin
               cx_in = cx_ff - cdy;
               cy_in = cy_ff + cdx;
               cz_in = cz_ff - ctab;
            end else begin
               cx_in = cx_ff + cdy;
               cy_in = cy_ff - cdx;
               cz_in = cz_ff + ctab;
            end
            cnt_in = cnt_ff + 5'd1;
         end
         ST_CDONE: begin
            cnt_in  = '0;
            vect_in = 1'b1;
            case (job_ff)
               JOB_APEX: begin
                  apex_in = zres;
                  cx_in   = ld_center.x;
                  cy_in   = ld_center.y;
                  cz_in   = ld_center.z;
                  zero_in = ld_center.zero;
                  job_in  = JOB_CENTER;
               end
               JOB_CENTER: begin
                  center_in = zres;
                  cx_in     = ld_vang.x;
                  cy_in     = ld_vang.y;
                  cz_in     = ld_vang.z;
                  zero_in   = ld_vang.zero;
                  job_in    = JOB_VANG;
               end
               JOB_VANG: vang_in = zres;
               default: begin
                  cos_in = neg_ff ? -signed'(cx_ff[31:0]) : signed'(cx_ff[31:0]);
                  sin_in = neg_ff ? -signed'(cy_ff[31:0]) : signed'(cy_ff[31:0]);
               end
            endcase
         end
         ST_CONE: begin
            left_in   = diff > 32'sd0;
            sq_rem_in = {vsq_ff, 16'd0};
            sq_res_in = '0;
            sq_bit_in = 50'(1) << 48;
            sq_job_in = SQ_MAG;
         end
         ST_EDGE_Y: ex_in = edge_val;
         ST_EDGE_WR: begin
            avoid_in[0] = sat16(29'(ex_ff) + 29'(nb_vel_ff[0]));
            avoid_in[1] = sat16(29'(edge_val) + 29'(nb_vel_ff[1]));
            // The edge keeps the relative z, which leaves the own z velocity.
            avoid_in[2] = own_vel_ff[2];
         end
         ST_EMIT: begin
            rsp_data_in  = {avoid_ff[2], avoid_ff[1], avoid_ff[0]};
            rsp_user_in  = vsq_ff > 34'(thresh_ff);
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Register update
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         radius_ff    <= RESET_SAFETY_RADIUS;
         horizon_ff   <= RESET_TIME_HORIZON;
         thresh_ff    <= RESET_OVERRIDE_THRESHOLD;
         for (int k = 0; k < 3; k++) begin
            own_pos_ff[k] <= '0;
            own_vel_ff[k] <= '0;
            avoid_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         radius_ff    <= radius_in;
         horizon_ff   <= horizon_in;
         thresh_ff    <= thresh_in;
         own_pos_ff   <= own_pos_in;
         own_vel_ff   <= own_vel_in;
         avoid_ff     <= avoid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff      <= job_in;
      sq_job_ff   <= sq_job_in;
      nb_vel_ff   <= nb_vel_in;
      rp_ff       <= rp_in;
      rv_ff       <= rv_in;
      step_ff     <= step_in;
      prod_ff     <= prod_in;
      dsq_ff      <= dsq_in;
      vsq_ff      <= vsq_in;
      rt_ff       <= rt_in;
      lim_ff      <= lim_in;
      r2_ff       <= r2_in;
      sq_rem_ff   <= sq_rem_in;
      sq_res_ff   <= sq_res_in;
      sq_bit_ff   <= sq_bit_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      cz_ff       <= cz_in;
      cnt_ff      <= cnt_in;
      vect_ff     <= vect_in;
      zero_ff     <= zero_in;
      neg_ff      <= neg_in;
      apex_ff     <= apex_in;
      center_ff   <= center_in;
      vang_ff     <= vang_in;
      left_ff     <= left_in;
      mag_ff      <= mag_in;
      cos_ff      <= cos_in;
      sin_ff      <= sin_in;
      ex_ff       <= ex_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_EMIT))
      else $error("result word raised outside the emit state");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_tready)
      else $error("input ready while the sequencer is busy");

   a_sqrt_bit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> $onehot(sq_bit_ff))
      else $error("square root trial bit lost");

   a_cordic_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CORD) |-> (cnt_ff <= LAST_ITER))
      else $error("CORDIC step count ran past the last iteration");

endmodule
